FILE: sv/sfr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the serial frame receiver
package sfr_pkg;

  localparam int DEF_LONG_FRAME_LEN = 23;
  localparam int SHORT_FRAME_LEN    = 4;
  localparam int FIELD_W            = 5;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;

  localparam logic [7:0]  START_BYTE_RST    = 8'h00;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

  localparam logic [7:0] MARK_A = 8'h0C;
  localparam logic [7:0] MARK_B = 8'h0D;
  localparam logic [7:0] MARK_C = 8'h13;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE    = 2'd0,
    CFG_TIMEOUT_TICKS = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         frame_byte;
    logic [FIELD_W-1:0] byte_index;
    logic [FIELD_W-1:0] payload_length;
    logic               status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               buf_sel;
    logic [FIELD_W-1:0] payload_length;
    logic               status;
  } frame_desc_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  function automatic logic is_short_marker(logic [7:0] b);
    return (b == MARK_A) || (b == MARK_B) || (b == MARK_C);
  endfunction

endpackage

FILE: sv/sfr_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/sfr_front.sv
`timescale 1ns / 1ps
// front end: config registers, start hunt, frame collection, checksum and timeout
module sfr_front import sfr_pkg::*; #(
  parameter int LONG_FRAME_LEN = DEF_LONG_FRAME_LEN
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data,
  input  logic                                  item_valid,
  input  in_item_t                              item,
  output logic                                  wr_en,
  output logic [$clog2(LONG_FRAME_LEN):0]       wr_addr,
  output logic [7:0]                            wr_data,
  output logic                                  desc_push,
  output frame_desc_t                           desc
);

  localparam int IDX_W = $clog2(LONG_FRAME_LEN);
  localparam int LEN_W = IDX_W + 1;
  localparam logic [LEN_W-1:0] LONG_LEN  = LEN_W'(LONG_FRAME_LEN);
  localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(SHORT_FRAME_LEN);
  localparam logic [IDX_W-1:0] MARK_POS  = IDX_W'(2);

  logic [7:0]       start_byte_r;
  logic [15:0]      timeout_r;
  logic             collecting_r, collecting_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [6:0]       sum_r, sum_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [7:0]       byte2_r, byte2_nxt;
  logic             wbuf_r, wbuf_nxt;
  logic [LEN_W-1:0] len;
  logic [16:0]      tick_inc;
  logic             done;

  always_comb begin
    collecting_nxt = collecting_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    tick_nxt       = tick_r;
    byte2_nxt      = byte2_r;
    wbuf_nxt       = wbuf_r;
    wr_en          = 1'b0;
    wr_addr        = {wbuf_r, count_r};
    wr_data        = item.rx_byte;
    desc_push      = 1'b0;
    desc.buf_sel   = wbuf_r;
    desc.payload_length = FIELD_W'(count_r);
    desc.status    = ({1'b0, sum_r} == item.rx_byte) ? STATUS_OK : STATUS_BAD;
    len            = {1'b0, count_r} + LEN_W'(1);
    tick_inc       = {1'b0, tick_r} + 17'd1;
    done           = ((len == SHORT_LEN) && is_short_marker(byte2_r)) || (len == LONG_LEN);

    if (item_valid) begin
      if (item.mode == MODE_TICK) begin
        if (collecting_r) begin
          tick_nxt = tick_inc[15:0];
          // timeout drops the partial frame silently
          if (tick_inc >= {1'b0, timeout_r}) begin
            collecting_nxt = 1'b0;
            count_nxt      = '0;
            sum_nxt        = '0;
            tick_nxt       = '0;
          end
        end
      end else if (!collecting_r) begin
        if (item.rx_byte == start_byte_r) begin
          collecting_nxt = 1'b1;
          wr_en          = 1'b1;
          wr_addr        = {wbuf_r, {IDX_W{1'b0}}};
          count_nxt      = IDX_W'(1);
          sum_nxt        = item.rx_byte[6:0];
          tick_nxt       = '0;
        end
      end else begin
        wr_en = 1'b1;
        if (count_r == MARK_POS) begin
          byte2_nxt = item.rx_byte;
        end
        if (done) begin
          // hand the frame to the back end and switch buffers
          desc_push      = 1'b1;
          wbuf_nxt       = ~wbuf_r;
          collecting_nxt = 1'b0;
          count_nxt      = '0;
          sum_nxt        = '0;
          tick_nxt       = '0;
        end else begin
          sum_nxt   = sum_r + item.rx_byte[6:0];
          count_nxt = len[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      timeout_r    <= TIMEOUT_TICKS_RST;
      collecting_r <= 1'b0;
      count_r      <= '0;
      sum_r        <= '0;
      tick_r       <= '0;
      wbuf_r       <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_START_BYTE)) begin
        start_byte_r <= cfg_data[7:0];
      end
      if (cfg_we && (cfg_index == CFG_TIMEOUT_TICKS)) begin
        timeout_r <= cfg_data;
      end
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
      tick_r       <= tick_nxt;
      wbuf_r       <= wbuf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte2_r <= byte2_nxt;
  end

endmodule

FILE: sv/sfr_desc_q.sv
`timescale 1ns / 1ps
// two-entry queue of completed frame descriptors between front and back end
module sfr_desc_q import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output frame_desc_t head,
  output logic        empty,
  output logic        full
);

  frame_desc_t entry_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: sv/sfr_back.sv
`timescale 1ns / 1ps
// back end: reads a stored frame out of the buffer ram into a result queue
module sfr_back import sfr_pkg::*; #(
  parameter int LONG_FRAME_LEN = DEF_LONG_FRAME_LEN
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             desc_empty,
  input  frame_desc_t                      desc_head,
  output logic                             desc_pop,
  output logic                             rd_en,
  output logic [$clog2(LONG_FRAME_LEN):0]  rd_addr,
  input  logic [7:0]                       rd_data,
  input  logic                             out_pop,
  output logic                             out_empty,
  output out_item_t                        out_item
);

  localparam int IDX_W = $clog2(LONG_FRAME_LEN);

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             inflight_r;
  out_item_t        meta_r, meta_nxt;
  out_item_t        ofifo_r [2];
  out_item_t        wr_entry;
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       occ;
  logic             popped;
  logic             is_last;

  assign out_empty = (cnt_r == 2'd0);
  assign out_item  = ofifo_r[rd_ptr_r];
  assign popped    = out_pop && !out_empty;
  // slots taken once the read in flight lands, counting this cycle's transfer out
  assign occ       = cnt_r + {1'b0, inflight_r} - {1'b0, popped};
  assign is_last   = (FIELD_W'(k_r) == (desc_head.payload_length - FIELD_W'(1)));
  assign rd_addr   = {desc_head.buf_sel, k_r};

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    rd_en     = 1'b0;
    desc_pop  = 1'b0;
    meta_nxt  = meta_r;
    case (state_r)
      BK_IDLE: begin
        if (!desc_empty) begin
          state_nxt = BK_RUN;
          k_nxt     = '0;
        end
      end
      BK_RUN: begin
        if (occ < 2'd2) begin
          rd_en                   = 1'b1;
          meta_nxt.frame_byte     = '0;
          meta_nxt.byte_index     = FIELD_W'(k_r);
          meta_nxt.payload_length = desc_head.payload_length;
          meta_nxt.status         = desc_head.status;
          meta_nxt.last           = is_last;
          if (is_last) begin
            desc_pop  = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    wr_entry            = meta_r;
    wr_entry.frame_byte = rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      k_r        <= '0;
      inflight_r <= 1'b0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      inflight_r <= rd_en;
      if (inflight_r) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (popped) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, inflight_r} - {1'b0, popped};
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
    if (inflight_r) begin
      ofifo_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

FILE: sv/serial_frame_receiver_sum7.sv
`timescale 1ns / 1ps
// serial frame receiver top: front end, descriptor queue, frame buffer ram, back end
// a byte or tick is taken on each in_push while in_full is low; in_full rises only while both
// frame buffers hold frames not yet drained. results flow one per cycle while out_pop keeps
// the two-entry result queue from filling, set by the single read port of the frame buffer
// ram, and the back end passes through its idle state between back-to-back frames.
// reset is synchronous active low: hunting, counters cleared, config back to defaults.
module serial_frame_receiver_sum7 import sfr_pkg::*; #(
  parameter int LONG_FRAME_LEN = DEF_LONG_FRAME_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W     = $clog2(LONG_FRAME_LEN);
  localparam int RAM_DEPTH = 2 << IDX_W;

  logic             in_accept;
  logic             wr_en;
  logic [IDX_W:0]   wr_addr;
  logic [7:0]       wr_data;
  logic             desc_push;
  frame_desc_t      desc;
  frame_desc_t      desc_head;
  logic             desc_pop;
  logic             desc_empty;
  logic             desc_full;
  logic             rd_en;
  logic [IDX_W:0]   rd_addr;
  logic [7:0]       rd_data;

  assign cfg_ready = 1'b1;
  assign in_full   = desc_full;
  assign in_accept = in_push && !in_full;

  sfr_front #(
    .LONG_FRAME_LEN(LONG_FRAME_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_valid(in_accept),
    .item      (in_item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .desc_push (desc_push),
    .desc      (desc)
  );

  sfr_desc_q u_desc_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (desc_push),
    .push_desc(desc),
    .pop      (desc_pop),
    .head     (desc_head),
    .empty    (desc_empty),
    .full     (desc_full)
  );

  sfr_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  sfr_back #(
    .LONG_FRAME_LEN(LONG_FRAME_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .desc_empty(desc_empty),
    .desc_head (desc_head),
    .desc_pop  (desc_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.last) |->
      (out_item.byte_index == out_item.payload_length - FIELD_W'(1)))
    else $error("last mark not on final byte of frame");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.byte_index < out_item.payload_length))
    else $error("byte index beyond payload length");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_item.payload_length == FIELD_W'(SHORT_FRAME_LEN - 1)) ||
                    (out_item.payload_length == FIELD_W'(LONG_FRAME_LEN - 1))))
    else $error("payload length is neither short nor long frame");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_item.last) |=>
      (out_empty || (out_item.byte_index == $past(out_item.byte_index) + FIELD_W'(1))))
    else $error("byte index did not advance by one after transfer");
`endif

endmodule
